// ===== hw/rtl/gradient_magnitude_direction_core_assert.svh =====
// Assertion helpers for the checker file.
`ifndef GRADIENT_MAGNITUDE_DIRECTION_CORE_ASSERT_SVH
`define GRADIENT_MAGNITUDE_DIRECTION_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define GMD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("gmd check failed");

// Condition that must never be seen at a clock edge.
`define GMD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`GMD_ASSERT(lbl, clk, rst_n, !(expr))

`endif

// ===== hw/rtl/gmd_pkg.sv =====
`default_nettype none
package gmd_pkg;
	localparam int MAX_WIDTH    = 4096;
	localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
	localparam int PIXEL_BITS   = 16;
	localparam int FW_BITS      = 13;
	localparam int FH_BITS      = 16;
	localparam int ROW_BITS     = 17;
	localparam int GRAD_BITS    = 22;
	localparam int SQ_BITS      = 45;
	localparam int CX_BITS      = 48;
	localparam int ACC_BITS     = 27;
	localparam int MAG_BITS     = 22;
	localparam int DIR_BITS     = 17;
	localparam int CORDIC_STEPS = 23;
	localparam int STEP_BITS    = 5;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_OPERATOR     = 2'd2;
	localparam logic [1:0] REG_DIR_ENABLE   = 2'd3;

	localparam logic [1:0] OP_CENTRAL = 2'd0;
	localparam logic [1:0] OP_PREWITT = 2'd1;
	localparam logic [1:0] OP_SOBEL   = 2'd2;
	localparam logic [1:0] OP_SCHARR  = 2'd3;

	typedef struct packed {
		logic                        start;
		logic                        ack;
		logic                        scale4;
		logic                        dir_en;
		logic signed [GRAD_BITS-1:0] gx;
		logic signed [GRAD_BITS-1:0] gy;
	} sol_req_t;

	typedef struct packed {
		logic                valid;
		logic [MAG_BITS-1:0] magnitude;
		logic [DIR_BITS-1:0] direction;
	} sol_rsp_t;

	// atan(2^-i) in units of pi/2^24
	function automatic logic [22:0] atan_unit(input logic [STEP_BITS-1:0] i);
		logic [22:0] a;
		case (i)
			5'd0:  a = 23'd4194304;
			5'd1:  a = 23'd2476042;
			5'd2:  a = 23'd1308273;
			5'd3:  a = 23'd664100;
			5'd4:  a = 23'd333339;
			5'd5:  a = 23'd166832;
			5'd6:  a = 23'd83436;
			5'd7:  a = 23'd41721;
			5'd8:  a = 23'd20861;
			5'd9:  a = 23'd10430;
			5'd10: a = 23'd5215;
			5'd11: a = 23'd2608;
			5'd12: a = 23'd1304;
			5'd13: a = 23'd652;
			5'd14: a = 23'd326;
			5'd15: a = 23'd163;
			5'd16: a = 23'd81;
			5'd17: a = 23'd41;
			5'd18: a = 23'd20;
			5'd19: a = 23'd10;
			5'd20: a = 23'd5;
			5'd21: a = 23'd3;
			5'd22: a = 23'd1;
			default: a = 23'd0;
		endcase
		return a;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/gmd_if.sv =====
`default_nettype none
interface gmd_pix_if import gmd_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;
	logic                  fill;
	modport source (output valid, pixel, fill, input ready);
	modport sink (input valid, pixel, fill, output ready);
endinterface

interface gmd_res_if import gmd_pkg::*;;
	logic                valid;
	logic                ready;
	logic [MAG_BITS-1:0] magnitude;
	logic [DIR_BITS-1:0] direction;
	logic                frame_end;
	modport source (output valid, magnitude, direction, frame_end, input ready);
	modport sink (input valid, magnitude, direction, frame_end, output ready);
endinterface

interface gmd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [15:0] wr_data;
	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gradient_magnitude_direction_core.sv =====
// Flow: an accepted pixel passes the read, tap and solve states before its result beat is loaded into a free output.
// A new pixel is taken only once the last result is loaded, as the 23-step root/CORDIC unit is shared;
//   items that give no result and fill beats that are dropped do not pass through the solver.
// Reset: asynchronous, active low; a clearing pass then zeroes the 4096-entry line store
//   with no pixel beat taken (config writes still taken).
`default_nettype none
module gradient_magnitude_direction_core import gmd_pkg::*; (
	input wire       clk,
	input wire       arst_n,
	gmd_pix_if.sink  pix,
	gmd_res_if.source res,
	gmd_cfg_if.sink  cfg
);
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_TAP   = 3'd3;
	localparam logic [2:0] ST_SOLVE = 3'd4;

	// configuration
	logic [FW_BITS-1:0] fw_q;
	logic [FH_BITS-1:0] fh_q;
	logic [1:0]         op_q;
	logic               dir_en_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= FW_BITS'(640);
			fh_q     <= FH_BITS'(480);
			op_q     <= OP_SOBEL;
			dir_en_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_FRAME_WIDTH:  fw_q     <= cfg.wr_data[FW_BITS-1:0];
				REG_FRAME_HEIGHT: fh_q     <= cfg.wr_data[FH_BITS-1:0];
				REG_OPERATOR:     op_q     <= cfg.wr_data[1:0];
				REG_DIR_ENABLE:   dir_en_q <= cfg.wr_data[0];
				default:          ;
			endcase
		end
	end

	// effective frame size: width clamped to 1..MAX_WIDTH, height at least two
	logic [FW_BITS-1:0]  w_eff;
	logic [ROW_BITS-1:0] h_eff;
	always_comb begin
		if (fw_q == '0)
			w_eff = FW_BITS'(1);
		else if (fw_q > FW_BITS'(MAX_WIDTH))
			w_eff = FW_BITS'(MAX_WIDTH);
		else
			w_eff = fw_q;
		h_eff = (fh_q < FH_BITS'(2)) ? ROW_BITS'(2) : ROW_BITS'(fh_q);
	end

	logic [2:0]            state_q;
	logic [ADDR_BITS-1:0]  clr_q, col_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [PIXEL_BITS-1:0] v_s1;
	logic [ADDR_BITS-1:0]  x_s2;
	logic [ROW_BITS-1:0]   row_s2;
	logic                  last_s2;
	logic [PIXEL_BITS-1:0] win_q [9];

	logic res_valid_q, end_q;
	logic [MAG_BITS-1:0] mag_q;
	logic [DIR_BITS-1:0] dir_q;

	logic flushing, last_now, emit_now, in_acc, out_load;
	logic [FW_BITS-1:0] col_inc;

	assign pix.ready = (state_q == ST_IDLE);
	assign in_acc    = pix.valid && pix.ready;
	assign flushing  = row_q >= h_eff;
	assign last_now  = row_q >= (h_eff + 1'b1);
	assign emit_now  = (row_q >= ROW_BITS'(2)) || (row_q == ROW_BITS'(1) && col_q != '0);
	assign col_inc   = FW_BITS'(col_q) + 1'b1;

	// line store: upper line in the high half, middle line in the low half
	logic [2*PIXEL_BITS-1:0] lmem [MAX_WIDTH];
	logic [2*PIXEL_BITS-1:0] rd_q, wr_data;
	logic [ADDR_BITS-1:0]    wr_addr;
	logic                    wr_en;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = col_q;
		wr_data = {rd_q[PIXEL_BITS-1:0], v_s1};
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == ST_READ) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) lmem[wr_addr] <= wr_data;
		rd_q <= lmem[col_q];
	end

	// solver handshake
	sol_req_t req;
	sol_rsp_t rsp;
	assign out_load = (state_q == ST_SOLVE) && rsp.valid && (!res_valid_q || res.ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					// drop fill beats until the last pixel of the frame is in
					if (in_acc && (flushing || !pix.fill)) state_q <= ST_READ;
				end
				ST_READ: begin
					for (int k = 0; k < 3; k++) begin
						win_q[k*3]   <= win_q[k*3+1];
						win_q[k*3+1] <= win_q[k*3+2];
					end
					win_q[2] <= rd_q[2*PIXEL_BITS-1:PIXEL_BITS];
					win_q[5] <= rd_q[PIXEL_BITS-1:0];
					win_q[8] <= v_s1;
					if (last_now) begin
						col_q <= '0;
						row_q <= '0;
					end else if (col_inc >= w_eff) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_inc[ADDR_BITS-1:0];
					end
					state_q <= emit_now ? ST_TAP : ST_IDLE;
				end
				ST_TAP: state_q <= ST_SOLVE;
				ST_SOLVE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload of the accepted beat and the window position it belongs to
	always_ff @(posedge clk) begin
		if (in_acc) v_s1 <= flushing ? '0 : pix.pixel;
		if (state_q == ST_READ) begin
			x_s2    <= col_q;
			row_s2  <= row_q;
			last_s2 <= last_now;
		end
	end

	// neighborhood with edge replication, centre one column behind the newest pixel
	logic [PIXEL_BITS-1:0] tp [3];
	logic [PIXEL_BITS-1:0] md [3];
	logic [PIXEL_BITS-1:0] bt [3];
	logic [FW_BITS-1:0]    cc;
	logic [ROW_BITS-1:0]   cr;

	always_comb begin
		cc = (x_s2 == '0) ? (w_eff - 1'b1) : FW_BITS'(x_s2 - 1'b1);
		cr = (x_s2 == '0) ? (row_s2 - ROW_BITS'(2)) : (row_s2 - ROW_BITS'(1));
		tp[0] = win_q[0]; tp[1] = win_q[1];
		md[0] = win_q[3]; md[1] = win_q[4];
		bt[0] = win_q[6]; bt[1] = win_q[7];
		tp[2] = (x_s2 == '0) ? win_q[1] : win_q[2];
		md[2] = (x_s2 == '0) ? win_q[4] : win_q[5];
		bt[2] = (x_s2 == '0) ? win_q[7] : win_q[8];
		if (cc == '0) begin
			tp[0] = tp[1]; md[0] = md[1]; bt[0] = bt[1];
		end
		if (cc >= w_eff - 1'b1) begin
			tp[2] = tp[1]; md[2] = md[1]; bt[2] = bt[1];
		end
		if (cr == '0) tp = md;
		if (cr >= h_eff - 1'b1) bt = md;
	end

	function automatic logic signed [PIXEL_BITS:0] pdiff(
		input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b
	);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	// weight side and centre terms: (0,1,0), (1,1,1), (1,2,1), (3,10,3)
	function automatic logic signed [GRAD_BITS-1:0] weigh(
		input logic [1:0]                op,
		input logic signed [PIXEL_BITS+1:0] s,
		input logic signed [PIXEL_BITS:0]   c
	);
		logic signed [GRAD_BITS-1:0] se, ce, g;
		se = GRAD_BITS'(s);
		ce = GRAD_BITS'(c);
		case (op)
			OP_CENTRAL: g = ce;
			OP_PREWITT: g = se + ce;
			OP_SOBEL:   g = se + (ce <<< 1);
			default:    g = (se <<< 1) + se + (ce <<< 3) + (ce <<< 1);
		endcase
		return g;
	endfunction

	logic signed [PIXEL_BITS+1:0] sx, sy;
	logic signed [PIXEL_BITS:0]   cx, cy;
	always_comb begin
		sx = (PIXEL_BITS+2)'(pdiff(tp[2], tp[0])) + (PIXEL_BITS+2)'(pdiff(bt[2], bt[0]));
		cx = pdiff(md[2], md[0]);
		sy = (PIXEL_BITS+2)'(pdiff(tp[0], bt[0])) + (PIXEL_BITS+2)'(pdiff(tp[2], bt[2]));
		cy = pdiff(tp[1], bt[1]);
	end

	assign req.start  = (state_q == ST_TAP);
	assign req.ack    = out_load;
	assign req.scale4 = (op_q != OP_PREWITT);
	assign req.dir_en = dir_en_q;
	assign req.gx     = weigh(op_q, sx, cx);
	assign req.gy     = weigh(op_q, sy, cy);

	gmd_solver u_solver (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_load)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mag_q <= rsp.magnitude;
			dir_q <= rsp.direction;
			end_q <= last_s2;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.magnitude = mag_q;
	assign res.direction = dir_q;
	assign res.frame_end = end_q;
endmodule
`default_nettype wire

// ===== hw/rtl/gmd_solver.sv =====
`default_nettype none
module gmd_solver import gmd_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  sol_req_t req,
	output sol_rsp_t rsp
);
	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_SQX  = 3'd1;
	localparam logic [2:0] P_SQY  = 3'd2;
	localparam logic [2:0] P_RUN  = 3'd3;
	localparam logic [2:0] P_HOLD = 3'd4;

	logic [2:0]                  phase_q;
	logic [STEP_BITS-1:0]        step_q;
	logic signed [GRAD_BITS-1:0] gx_q, gy_q;
	logic                        scale_q, dir_en_q, spec_q;
	logic [DIR_BITS-1:0]         spec_dir_q;
	logic [SQ_BITS-1:0]          sq_q, rem_q, root_q;
	logic signed [CX_BITS-1:0]   x_q, y_q;
	logic signed [ACC_BITS-1:0]  acc_q;

	logic signed [GRAD_BITS-1:0]   mul_in, gxn, gyn;
	logic signed [2*GRAD_BITS-1:0] prod;
	logic signed [CX_BITS-1:0]     xs, ys, dx, dy;
	logic [SQ_BITS-1:0]            bval, trial, qsum;
	logic [5:0]                    bshift;
	logic signed [ACC_BITS-1:0]    atan_s;

	assign mul_in = (phase_q == P_SQX) ? gx_q : gy_q;
	assign prod   = mul_in * mul_in;
	assign qsum   = sq_q + SQ_BITS'($unsigned(prod));

	assign gxn = req.gy[GRAD_BITS-1] ? -req.gx : req.gx;
	assign gyn = req.gy[GRAD_BITS-1] ? -req.gy : req.gy;
	assign xs  = CX_BITS'(gxn) <<< 24;
	assign ys  = CX_BITS'(gyn) <<< 24;

	assign bshift = 6'(2 * (CORDIC_STEPS - 1)) - {step_q, 1'b0};
	assign bval   = SQ_BITS'(1) << bshift;
	assign trial  = root_q + bval;
	assign dx     = y_q >>> step_q;
	assign dy     = x_q >>> step_q;
	assign atan_s = $signed({{(ACC_BITS-23){1'b0}}, atan_unit(step_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			step_q  <= '0;
		end else begin
			unique case (phase_q)
				P_IDLE: if (req.start) phase_q <= P_SQX;
				P_SQX:  phase_q <= P_SQY;
				P_SQY: begin
					phase_q <= P_RUN;
					step_q  <= '0;
				end
				P_RUN: begin
					if (step_q == STEP_BITS'(CORDIC_STEPS - 1)) phase_q <= P_HOLD;
					step_q <= step_q + 1'b1;
				end
				P_HOLD: if (req.ack) phase_q <= P_IDLE;
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == P_IDLE && req.start) begin
			gx_q     <= req.gx;
			gy_q     <= req.gy;
			scale_q  <= req.scale4;
			dir_en_q <= req.dir_en;
			// fold into the upper half plane, quarter turn when left of the axis
			spec_q     <= (req.gy == '0) || (gxn == '0);
			spec_dir_q <= (req.gy == '0) ? (req.gx[GRAD_BITS-1] ? DIR_BITS'(65536) : '0)
				: DIR_BITS'(32768);
			if (gxn[GRAD_BITS-1]) begin
				x_q   <= ys;
				y_q   <= -xs;
				acc_q <= ACC_BITS'(1) <<< 23;
			end else begin
				x_q   <= xs;
				y_q   <= ys;
				acc_q <= '0;
			end
		end
		if (phase_q == P_SQX) sq_q <= SQ_BITS'($unsigned(prod));
		if (phase_q == P_SQY) begin
			rem_q  <= scale_q ? (qsum << 2) : qsum;
			root_q <= '0;
		end
		if (phase_q == P_RUN) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bval;
			end else begin
				root_q <= root_q >> 1;
			end
			// freeze once y reaches zero
			if (y_q != '0) begin
				if (!y_q[CX_BITS-1]) begin
					x_q   <= x_q + dx;
					y_q   <= y_q - dy;
					acc_q <= acc_q + atan_s;
				end else begin
					x_q   <= x_q - dx;
					y_q   <= y_q + dy;
					acc_q <= acc_q - atan_s;
				end
			end
		end
	end

	logic [DIR_BITS-1:0] dir_clamped;
	always_comb begin
		if (acc_q[ACC_BITS-1])
			dir_clamped = '0;
		else if (acc_q > (ACC_BITS'(1) <<< 24))
			dir_clamped = DIR_BITS'(65536);
		else
			dir_clamped = acc_q[24:8];
	end

	assign rsp.valid     = (phase_q == P_HOLD);
	assign rsp.magnitude = root_q[MAG_BITS-1:0];
	assign rsp.direction = !dir_en_q ? '0 : (spec_q ? spec_dir_q : dir_clamped);
endmodule
`default_nettype wire

// ===== hw/rtl/gmd_checker.sv =====
`default_nettype none
`include "gradient_magnitude_direction_core_assert.svh"
module gmd_checker import gmd_pkg::*; (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_ready,
	input wire                in_fill,
	input wire                out_valid,
	input wire                out_ready,
	input wire [MAG_BITS-1:0] out_mag,
	input wire [DIR_BITS-1:0] out_dir,
	input wire                out_end
);
	`GMD_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`GMD_ASSERT(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_mag) && $stable(out_dir) && $stable(out_end))
	`GMD_ASSERT(a_busy_after_pixel, clk, arst_n, in_valid && in_ready && !in_fill |=> !in_ready)
	`GMD_ASSERT_NEVER(a_no_instant_result, clk, arst_n, $past(in_valid && in_ready) && $rose(out_valid))
endmodule

bind gradient_magnitude_direction_core gmd_checker u_gmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix.valid),
	.in_ready  (pix.ready),
	.in_fill   (pix.fill),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_mag   (res.magnitude),
	.out_dir   (res.direction),
	.out_end   (res.frame_end)
);
`default_nettype wire
